// File: rtl/pwsp_pkg.sv
// ----------------------------------------------------------------------------
// pwsp_pkg
// Shared types and codes for the protobuf wire stream parser.
// ----------------------------------------------------------------------------
package pwsp_pkg;

  // width of the payload length counter
  localparam int LEN_BITS = 32;
  localparam logic [63:0] LEN_MAX = (LEN_BITS >= 64) ? {64{1'b1}} :
                                    ((64'd1 << LEN_BITS) - 64'd1);

  // parser phases
  localparam logic [2:0] PH_KEY     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIXED   = 3'd2;
  localparam logic [2:0] PH_LEN     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // wire types from the key
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_VARINT  = 2'd0;
  localparam logic [1:0] KIND_FIXED64 = 2'd1;
  localparam logic [1:0] KIND_FIXED32 = 2'd2;
  localparam logic [1:0] KIND_LEN     = 2'd3;

  localparam logic [7:0] VAR_MASK = 8'h7f;
  localparam logic [7:0] VAR_MORE = 8'h80;

  typedef struct packed {
    logic [1:0]  field_kind;
    logic [31:0] field_number;
    logic [63:0] field_value;
    logic        empty_field;
    logic        last_of_field;
  } pwsp_result_t;

endpackage

// File: rtl/protobuf_wire_stream_parser_core.sv
// latency: a result appears on out_* the cycle after its byte beat is accepted
// throughput: one byte beat per cycle while in_tready is high; the result register frees as it is taken
// in_tready falls only while a result is held and out_tready is low
// reset: synchronous active-low rst_n returns the parser to key phase,
// clears the value and length state and empties the result register
// ----------------------------------------------------------------------------
// protobuf_wire_stream_parser_core
// Byte-per-beat protobuf wire format decoder with registered result stream.
// ----------------------------------------------------------------------------
module protobuf_wire_stream_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // field_number[31:0], field_value[95:32]
  output logic [2:0]  out_tuser,  // field_kind[1:0], empty_field[2]
  output logic        out_tlast   // last_of_field
);
  import pwsp_pkg::*;

  logic         beat_en;
  logic         res_valid;
  pwsp_result_t res;
  pwsp_result_t held;

  assign beat_en = in_tvalid && in_tready;

  pwsp_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat_en       (beat_en),
    .message_start (in_tuser),
    .data_byte     (in_tdata),
    .res_valid     (res_valid),
    .res           (res)
  );

  pwsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (beat_en && res_valid),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .space     (in_tready),
    .held      (held)
  );

  assign out_tdata = {held.field_value, held.field_number};
  assign out_tuser = {held.empty_field, held.field_kind};
  assign out_tlast = held.last_of_field;

`ifndef SYNTHESIS
  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2]
    |-> out_tlast && out_tuser[1:0] == KIND_LEN && out_tdata[95:32] == 64'd0)
    else $error("malformed empty field result");

  a_scalar_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != KIND_LEN |-> out_tlast && !out_tuser[2])
    else $error("scalar result without last mark");

  a_payload_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == KIND_LEN |-> out_tdata[95:40] == 56'd0)
    else $error("payload result wider than a byte");
`endif

endmodule

// File: rtl/pwsp_decode.sv
// ----------------------------------------------------------------------------
// pwsp_decode
// Parser state and per-byte next-state logic; produces at most one result.
// ----------------------------------------------------------------------------
module pwsp_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat_en,
  input  logic                  message_start,
  input  logic [7:0]            data_byte,
  output logic                  res_valid,
  output pwsp_pkg::pwsp_result_t res
);
  import pwsp_pkg::*;

  logic [2:0]          phase_r, phase_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [3:0]          gc_r, gc_nxt;
  logic [31:0]         field_r, field_nxt;
  logic [2:0]          wt_r, wt_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;

  logic [2:0]          eff_phase;
  logic [63:0]         eff_acc;
  logic [3:0]          eff_gc;
  logic [31:0]         eff_field;
  logic [2:0]          eff_wt;
  logic [LEN_BITS-1:0] eff_rem;

  logic [63:0]         varint_acc;
  logic [63:0]         fixed_acc;
  logic [3:0]          gc_inc;
  logic [6:0]          var_sh;
  logic                more;
  logic [3:0]          need;
  logic [63:0]         len_sat;

  // a message start drops everything in progress before the byte is used
  always_comb begin
    eff_phase = message_start ? PH_KEY : phase_r;
    eff_acc   = message_start ? 64'd0 : acc_r;
    eff_gc    = message_start ? 4'd0 : gc_r;
    eff_field = message_start ? 32'd0 : field_r;
    eff_wt    = message_start ? 3'd0 : wt_r;
    eff_rem   = message_start ? '0 : rem_r;
  end

  assign more   = (data_byte & VAR_MORE) != 8'd0;
  assign gc_inc = (eff_gc == 4'd15) ? 4'd15 : eff_gc + 4'd1;
  assign var_sh = 7'(eff_gc) * 7'd7;
  assign need   = (eff_wt == WT_FIXED64) ? 4'd8 : 4'd4;

  always_comb begin
    varint_acc = eff_acc;
    if (eff_gc <= 4'd9) begin
      varint_acc = eff_acc | ({56'd0, data_byte & VAR_MASK} << var_sh);
    end
    fixed_acc = eff_acc;
    if (eff_gc < 4'd8) begin
      fixed_acc = eff_acc | ({56'd0, data_byte} << {eff_gc[2:0], 3'b000});
    end
  end

  assign len_sat = (varint_acc > LEN_MAX) ? LEN_MAX : varint_acc;

  always_comb begin
    phase_nxt = eff_phase;
    acc_nxt   = eff_acc;
    gc_nxt    = eff_gc;
    field_nxt = eff_field;
    wt_nxt    = eff_wt;
    rem_nxt   = eff_rem;
    res_valid = 1'b0;
    res.field_kind    = KIND_VARINT;
    res.field_number  = eff_field;
    res.field_value   = 64'd0;
    res.empty_field   = 1'b0;
    res.last_of_field = 1'b1;
    case (eff_phase)
      PH_VARINT: begin
        acc_nxt = varint_acc;
        gc_nxt  = gc_inc;
        if (!more) begin
          res_valid       = 1'b1;
          res.field_value = varint_acc;
          acc_nxt         = 64'd0;
          gc_nxt          = 4'd0;
          phase_nxt       = PH_KEY;
        end
      end
      PH_FIXED: begin
        acc_nxt = fixed_acc;
        gc_nxt  = gc_inc;
        if (gc_inc >= need) begin
          res_valid       = 1'b1;
          res.field_kind  = (need == 4'd8) ? KIND_FIXED64 : KIND_FIXED32;
          res.field_value = fixed_acc;
          acc_nxt         = 64'd0;
          gc_nxt          = 4'd0;
          phase_nxt       = PH_KEY;
        end
      end
      PH_LEN: begin
        acc_nxt = varint_acc;
        gc_nxt  = gc_inc;
        if (!more) begin
          acc_nxt = 64'd0;
          gc_nxt  = 4'd0;
          if (len_sat == 64'd0) begin
            res_valid       = 1'b1;
            res.field_kind  = KIND_LEN;
            res.empty_field = 1'b1;
            phase_nxt       = PH_KEY;
          end else begin
            rem_nxt   = len_sat[LEN_BITS-1:0];
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.field_kind    = KIND_LEN;
        res.field_value   = {56'd0, data_byte};
        res.last_of_field = (eff_rem <= LEN_BITS'(1));
        if (eff_rem <= LEN_BITS'(1)) begin
          rem_nxt   = '0;
          phase_nxt = PH_KEY;
        end else begin
          rem_nxt = eff_rem - LEN_BITS'(1);
        end
      end
      default: begin
        acc_nxt   = varint_acc;
        gc_nxt    = gc_inc;
        phase_nxt = PH_KEY;
        if (!more) begin
          field_nxt = varint_acc[34:3];
          wt_nxt    = varint_acc[2:0];
          acc_nxt   = 64'd0;
          gc_nxt    = 4'd0;
          case (varint_acc[2:0])
            WT_VARINT:  phase_nxt = PH_VARINT;
            WT_FIXED64: phase_nxt = PH_FIXED;
            WT_LEN:     phase_nxt = PH_LEN;
            WT_FIXED32: phase_nxt = PH_FIXED;
            default:    phase_nxt = PH_KEY;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      acc_r   <= 64'd0;
      gc_r    <= 4'd0;
      field_r <= 32'd0;
      wt_r    <= 3'd0;
      rem_r   <= '0;
    end else if (beat_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      gc_r    <= gc_nxt;
      field_r <= field_nxt;
      wt_r    <= wt_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIXED |-> gc_r < 4'd8)
    else $error("fixed byte count out of range");

  a_payload_stays: assert property (@(posedge clk) disable iff (!rst_n)
    beat_en && !message_start && phase_r == PH_PAYLOAD && rem_r > LEN_BITS'(1)
    |=> phase_r == PH_PAYLOAD)
    else $error("payload ended early");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with zero bytes remaining");
`endif

endmodule

// File: rtl/pwsp_out_reg.sv
// ----------------------------------------------------------------------------
// pwsp_out_reg
// Result register; takes a new result when empty or while the held one is being taken.
// ----------------------------------------------------------------------------
module pwsp_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  pwsp_pkg::pwsp_result_t res,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  space,
  output pwsp_pkg::pwsp_result_t held
);
  import pwsp_pkg::*;

  logic         valid_r, valid_nxt;
  pwsp_result_t held_r;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign held      = held_r;

endmodule
